// ===== rtl/text_console_writer_macros.svh =====
// Assertion macros used by the console writer engine
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define TCW_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tcw assertion failed");

// Antecedent in one cycle implies consequent in the next
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

// ===== rtl/tcw_pkg.sv =====
// Types and constants shared by the console writer modules
package tcw_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [15:0] RESET_BLANK  = 16'h0F20;

    localparam logic CFG_FOREGROUND = 1'b0;
    localparam logic CFG_BACKGROUND = 1'b1;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } t_req;

    typedef struct packed {
        logic [15:0] read_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic        did_scroll;
    } t_res;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/tcw_engine.sv =====
// Console sequencer: cursor, shared address adder, scroll copy and fill sweeps
`include "text_console_writer_macros.svh"

module tcw_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_attr,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  tcw_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output tcw_pkg::t_res o_res
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [AW-1:0] COL_STEP = AW'(COLUMNS);
    localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] CNT_LAST = AW'(CELLS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NEXT,
        S_COPY,
        S_FILL,
        S_RD_WAIT,
        S_DONE
    } t_state;

    t_state        r_state;
    t_req          r_req;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_row_base;
    logic [AW-1:0] r_cnt;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic [15:0]   r_fill;
    logic          r_init;
    logic [15:0]   r_rd_data;
    logic          r_scroll;

    // shared address adder
    logic [AW-1:0] add_a;
    logic [AW-1:0] add_b;
    logic [AW-1:0] add_sum;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [15:0]   mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [15:0]   mem_rd_data;
    logic          addr_ok;

    assign addr_ok = (32'(r_req.cell_address) < CELLS);

    always_comb begin
        add_a = r_row_base;
        add_b = AW'(r_col);
        if (r_state == S_COPY) begin
            add_a = r_cnt;
            add_b = COL_STEP;
        end else if (r_state == S_NEXT) begin
            add_b = COL_STEP;
        end
    end

    assign add_sum = add_a + add_b;

    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_cnt;
        mem_wr_data = r_fill;
        mem_rd_en   = 1'b0;
        mem_rd_addr = add_sum;
        unique case (r_state)
            S_EXEC: begin
                if (r_req.op == OP_PUT && r_req.char_code != NEWLINE_CODE) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = add_sum;
                    mem_wr_data = {i_attr, r_req.char_code};
                end
                if (r_req.op == OP_READ && addr_ok) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(r_req.cell_address);
                end
            end
            S_COPY: begin
                mem_rd_en   = (r_cnt != COPY_END);
                mem_wr_en   = r_wr_pend;
                mem_wr_addr = r_wr_addr;
                mem_wr_data = mem_rd_data;
            end
            S_FILL: begin
                mem_wr_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_FILL;
            r_row      <= '0;
            r_col      <= '0;
            r_row_base <= '0;
            r_cnt      <= '0;
            r_wr_pend  <= 1'b0;
            r_fill     <= RESET_BLANK;
            r_init     <= 1'b1;
            r_scroll   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req     <= i_req;
                        r_scroll  <= 1'b0;
                        r_rd_data <= '0;
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_req.op)
                        OP_PUT: begin
                            if (r_req.char_code == NEWLINE_CODE) begin
                                r_state <= S_NEXT;
                            end else if (r_col == COL_LAST) begin
                                r_state <= S_NEXT;
                            end else begin
                                r_col   <= r_col + 1'b1;
                                r_state <= S_DONE;
                            end
                        end
                        OP_READ: begin
                            r_state <= S_RD_WAIT;
                        end
                        OP_CLEAR: begin
                            r_fill  <= {i_attr, SPACE_CODE};
                            r_cnt   <= '0;
                            r_state <= S_FILL;
                        end
                        OP_NONE: begin
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_NEXT: begin
                    r_col <= '0;
                    if (r_row == ROW_LAST) begin
                        r_scroll  <= 1'b1;
                        r_fill    <= {i_attr, SPACE_CODE};
                        r_cnt     <= '0;
                        r_wr_pend <= 1'b0;
                        r_state   <= S_COPY;
                    end else begin
                        r_row      <= r_row + 1'b1;
                        r_row_base <= add_sum;
                        r_state    <= S_DONE;
                    end
                end
                S_COPY: begin
                    // read one row ahead, write the previous read back one row up
                    if (r_cnt != COPY_END) begin
                        r_wr_addr <= r_cnt;
                        r_wr_pend <= 1'b1;
                        r_cnt     <= r_cnt + 1'b1;
                    end else begin
                        r_wr_pend <= 1'b0;
                        r_state   <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (r_cnt == CNT_LAST) begin
                        r_init  <= 1'b0;
                        r_state <= r_init ? S_IDLE : S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_RD_WAIT: begin
                    r_rd_data <= addr_ok ? mem_rd_data : '0;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready           = (r_state == S_IDLE);
    assign o_res_valid           = (r_state == S_DONE);
    assign o_res.read_data       = r_rd_data;
    assign o_res.cursor_row      = 5'(r_row);
    assign o_res.cursor_column   = 7'(r_col);
    assign o_res.did_scroll      = r_scroll;

    `TCW_ASSERT(a_row_range, i_clk, i_rst_n, r_row <= ROW_LAST)
    `TCW_ASSERT(a_row_base, i_clk, i_rst_n, r_row_base == AW'(32'(r_row) * COLUMNS))
    `TCW_ASSERT_NEXT(a_scroll_stays, i_clk, i_rst_n, r_state == S_NEXT && r_row == ROW_LAST, r_state == S_COPY && r_row == ROW_LAST && r_scroll && r_col == '0)
    `TCW_ASSERT(a_idle_no_write, i_clk, i_rst_n, !(r_state == S_IDLE && mem_wr_en))

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: stream ports, colour registers, result register
//
// Text console over a ROWS x COLUMNS store of 16-bit cells (attribute<<8 | char).
// One item is taken at a time; the sequencer holds tready low until its result has
// moved into the output register. Put and unused operations pass the execute state
// only; a read adds a read-wait state, and a put that ends a row or a newline adds a
// next-row state. A scroll copies the store one row up through the single RAM write
// port, one cell a cycle, then fills the bottom row. A clear writes every cell once.
// After reset a clearing pass writes blank cells while tready stays low; colour
// writes are taken throughout.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [7:0] char_code, [18:8] cell_address, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] operation
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // [15:0] read_data, [20:16] cursor_row,
                                     // [27:21] cursor_column, [28] did_scroll, rest zero
);
    import tcw_pkg::*;

    logic [3:0]  r_fg;
    logic [3:0]  r_bg;
    logic        r_out_valid;
    t_res        r_out;

    t_req        req;
    t_res        res;
    logic        res_valid;
    logic        res_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd15;
            r_bg <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FOREGROUND: r_fg <= i_cfg_data;
                CFG_BACKGROUND: r_bg <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign req.op           = t_op'(i_s_tuser);
    assign req.char_code    = i_s_tdata[7:0];
    assign req.cell_address = i_s_tdata[18:8];

    tcw_engine #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      ({r_bg, r_fg}),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register frees the sequencer once the result transfer is set up
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
            if (res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.did_scroll, r_out.cursor_column,
                         r_out.cursor_row, r_out.read_data};

endmodule
